// ----- hdl/channelizer_output_permute_assert.svh -----
// Assertion macros used by the back end of the channelizer output permutation RTL.
`ifndef CHANNELIZER_OUTPUT_PERMUTE_ASSERT_SVH
`define CHANNELIZER_OUTPUT_PERMUTE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define CHOP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define CHOP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/chop_pkg.sv -----
// Shared constants and types of the channelizer output permutation.
package chop_pkg;

  localparam int LANES       = 8;
  localparam int LANE_W      = $clog2(LANES);
  localparam int ROT_W       = LANE_W + 1;
  localparam int BANKS       = 4;
  localparam int PARTS       = 2;
  localparam int SAMPLE_BITS = 32;
  localparam int FIELD_BITS  = 32;
  localparam int LANE_FIELD_W = 3;
  localparam int STEP_W      = 3;
  localparam int DELAY_CALLS = 4;
  localparam int DELAY_SLOTS = DELAY_CALLS + 1;
  localparam int SLOT_W      = $clog2(DELAY_SLOTS);
  localparam int HALF_W      = 2;
  localparam int WARM_MAX    = (DELAY_CALLS > 2) ? DELAY_CALLS : 2;
  localparam int WARM_W      = $clog2(WARM_MAX + 1);
  localparam int BANK_AW     = HALF_W + LANE_W;
  localparam int BANK_DEPTH  = 1 << BANK_AW;
  localparam int DLY_AW      = SLOT_W + LANE_W;
  localparam int DLY_DEPTH   = 1 << DLY_AW;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  // One call's worth of work handed from the front to the back.
  typedef struct packed {
    logic [HALF_W-1:0] rd_half;
    logic              odd;
    logic              fresh_ok;
    logic              aged_ok;
    logic [SLOT_W-1:0] wr_slot;
    logic [SLOT_W-1:0] rd_slot;
    logic [STEP_W-1:0] step;
  } chop_job_t;

  typedef struct packed {
    logic                 en;
    logic                 part;
    logic [BANK_AW-1:0]   addr;
    sample_t [BANKS-1:0]  data;
  } chop_bwr_t;

  typedef struct packed {
    logic               en;
    logic [BANK_AW-1:0] addr;
  } chop_brd_t;

  typedef sample_t [BANKS-1:0][PARTS-1:0] bank_data_t;

endpackage

// ----- hdl/chop_if.sv -----
// Input and output word channels of the channelizer output permutation.
interface chop_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] in_sample_a;
  logic [31:0] in_sample_b;
  logic [31:0] in_sample_c;
  logic [31:0] in_sample_d;

  modport source (output valid, in_sample_a, in_sample_b, in_sample_c, in_sample_d,
                  input ready);
  modport sink (input valid, in_sample_a, in_sample_b, in_sample_c, in_sample_d,
                output ready);
endinterface

interface chop_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_lane;
  logic [31:0] out_sample_a;
  logic [31:0] out_sample_b;
  logic [31:0] out_sample_c;
  logic [31:0] out_sample_d;
  logic        out_last;

  modport source (output valid, out_lane, out_sample_a, out_sample_b, out_sample_c,
                  out_sample_d, out_last, input ready);
  modport sink (input valid, out_lane, out_sample_a, out_sample_b, out_sample_c,
                out_sample_d, out_last, output ready);
endinterface

// ----- hdl/chop_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module chop_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/chop_front.sv -----
// Front end: accepts lane words, writes the bank store and queues one job per call.
module chop_front (
  input  logic                clk,
  input  logic                rst_n,
  chop_in_if.sink             in_ch,
  input  logic                q_full,
  output logic                q_push,
  output chop_pkg::chop_job_t q_job,
  output chop_pkg::chop_bwr_t bwr
);

  logic [chop_pkg::LANE_W-1:0] lane_r, lane_nxt;
  logic                        odd_r, odd_nxt;
  logic [chop_pkg::HALF_W-1:0] pair_r, pair_nxt;
  logic [chop_pkg::SLOT_W-1:0] slot_r, slot_nxt, slot_inc;
  logic [chop_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [chop_pkg::WARM_W-1:0] warm_r, warm_nxt;
  logic                        last_lane;
  logic                        accept;
  logic [chop_pkg::ROT_W-1:0]  row;

  assign last_lane   = (lane_r == chop_pkg::LANE_W'(chop_pkg::LANES - 1));
  assign in_ch.ready = !(last_lane && q_full);
  assign accept      = in_ch.valid && in_ch.ready;

  // Lane L of a call lands on row 2*L+odd; the row's top bit picks the bank part.
  assign row = {lane_r, odd_r};

  always_comb begin
    bwr.en      = accept;
    bwr.part    = row[chop_pkg::LANE_W];
    bwr.addr    = {pair_r, row[chop_pkg::LANE_W-1:0]};
    bwr.data[0] = chop_pkg::SAMPLE_BITS'(in_ch.in_sample_a);
    bwr.data[1] = chop_pkg::SAMPLE_BITS'(in_ch.in_sample_b);
    bwr.data[2] = chop_pkg::SAMPLE_BITS'(in_ch.in_sample_c);
    bwr.data[3] = chop_pkg::SAMPLE_BITS'(in_ch.in_sample_d);
  end

  assign slot_inc = (slot_r == chop_pkg::SLOT_W'(chop_pkg::DELAY_SLOTS - 1)) ?
                    '0 : slot_r + 1'b1;

  always_comb begin
    q_push         = accept && last_lane;
    q_job.rd_half  = pair_r - 1'b1;
    q_job.odd      = odd_r;
    q_job.fresh_ok = (warm_r >= chop_pkg::WARM_W'(2));
    q_job.aged_ok  = (warm_r >= chop_pkg::WARM_W'(chop_pkg::DELAY_CALLS));
    q_job.wr_slot  = slot_r;
    q_job.rd_slot  = slot_inc;
    q_job.step     = step_r;
  end

  always_comb begin
    lane_nxt = lane_r;
    odd_nxt  = odd_r;
    pair_nxt = pair_r;
    slot_nxt = slot_r;
    step_nxt = step_r;
    warm_nxt = warm_r;
    if (accept) begin
      lane_nxt = lane_r + 1'b1;
      if (last_lane) begin
        lane_nxt = '0;
        odd_nxt  = !odd_r;
        if (odd_r) begin
          pair_nxt = pair_r + 1'b1;
        end
        slot_nxt = slot_inc;
        step_nxt = step_r + chop_pkg::STEP_W'(2);
        if (warm_r != chop_pkg::WARM_W'(chop_pkg::WARM_MAX)) begin
          warm_nxt = warm_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r <= '0;
      odd_r  <= 1'b0;
      pair_r <= '0;
      slot_r <= '0;
      step_r <= '0;
      warm_r <= '0;
    end else begin
      lane_r <= lane_nxt;
      odd_r  <= odd_nxt;
      pair_r <= pair_nxt;
      slot_r <= slot_nxt;
      step_r <= step_nxt;
      warm_r <= warm_nxt;
    end
  end

endmodule

// ----- hdl/chop_queue.sv -----
// Two-entry job queue between the front end and the back end.
module chop_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  chop_pkg::chop_job_t push_job,
  output logic                full,
  output logic                nonempty,
  output chop_pkg::chop_job_t head,
  input  logic                pop
);

  chop_pkg::chop_job_t              job_r [chop_pkg::QUEUE_DEPTH];
  logic [chop_pkg::QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [chop_pkg::QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [chop_pkg::QUEUE_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == chop_pkg::QUEUE_CNT_W'(chop_pkg::QUEUE_DEPTH));
  assign nonempty = (cnt_r != '0);
  assign head     = job_r[rd_ptr_r];

  // The depth is a power of two, so the pointers wrap on their own.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      job_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ----- hdl/chop_back.sv -----
// Back end: copies fresh rows into the delay store and emits rotated output words.
`include "channelizer_output_permute_assert.svh"

module chop_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  chop_pkg::chop_job_t  job,
  output logic                 q_pop,
  output chop_pkg::chop_brd_t  brd,
  input  chop_pkg::bank_data_t bdata,
  chop_out_if.source           out_ch
);

  logic [chop_pkg::LANE_W-1:0] j_r, j_nxt;
  logic                        b_v_r, b_v_nxt;
  logic                        o_v_r, o_v_nxt;
  logic                        issue;
  logic                        b_adv;
  logic [chop_pkg::STEP_W-1:0] step1;
  logic [chop_pkg::ROT_W-1:0]  shift0, shift1, m0, m1;
  logic [chop_pkg::DLY_AW-1:0] dly_raddr [2];
  logic [chop_pkg::DLY_AW-1:0] dly_waddr;

  // Read stage side information.
  logic [chop_pkg::LANE_W-1:0] b_lane_r;
  logic                        b_sel0_r, b_sel1_r;
  logic                        b_fresh_ok_r, b_aged_ok_r, b_odd_r;
  logic [chop_pkg::SLOT_W-1:0] b_slot_r;

  chop_pkg::sample_t fresh  [2][chop_pkg::PARTS];
  chop_pkg::sample_t aged   [2][chop_pkg::PARTS];
  chop_pkg::sample_t dly_rd [2][chop_pkg::PARTS];

  // Output register.
  logic [chop_pkg::LANE_FIELD_W-1:0] o_lane_r;
  logic [chop_pkg::FIELD_BITS-1:0]   o_a_r, o_b_r, o_c_r, o_d_r;
  logic                              o_last_r;

  assign b_adv = b_v_r && (!o_v_r || out_ch.ready);
  assign issue = q_valid && (!b_v_r || b_adv);
  assign q_pop = issue && (j_r == chop_pkg::LANE_W'(chop_pkg::LANES - 1));

  // Row element m of the rotated row is aged element (m + 2*step) mod row length.
  // Elements m and m+LANES live at the same index of the two parts.
  assign step1  = job.step + 1'b1;
  assign shift0 = chop_pkg::ROT_W'({job.step, 1'b0});
  assign shift1 = chop_pkg::ROT_W'({step1, 1'b0});
  assign m0     = chop_pkg::ROT_W'(j_r) + shift0;
  assign m1     = chop_pkg::ROT_W'(j_r) + shift1;

  assign dly_raddr[0] = {job.rd_slot, m0[chop_pkg::LANE_W-1:0]};
  assign dly_raddr[1] = {job.rd_slot, m1[chop_pkg::LANE_W-1:0]};
  assign dly_waddr    = {b_slot_r, b_lane_r};

  assign brd.en   = issue;
  assign brd.addr = {job.rd_half, j_r};

  // Even calls take banks 0 and 1, odd calls banks 2 and 3.
  always_comb begin
    for (int p = 0; p < chop_pkg::PARTS; p++) begin
      fresh[0][p] = '0;
      fresh[1][p] = '0;
      if (b_fresh_ok_r) begin
        fresh[0][p] = b_odd_r ? bdata[2][p] : bdata[0][p];
        fresh[1][p] = b_odd_r ? bdata[3][p] : bdata[1][p];
      end
      aged[0][p] = b_aged_ok_r ? dly_rd[0][p] : '0;
      aged[1][p] = b_aged_ok_r ? dly_rd[1][p] : '0;
    end
  end

  for (genvar r = 0; r < 2; r++) begin : g_row
    for (genvar p = 0; p < chop_pkg::PARTS; p++) begin : g_part
      chop_ram #(
        .WIDTH (chop_pkg::SAMPLE_BITS),
        .DEPTH (chop_pkg::DLY_DEPTH)
      ) u_dly (
        .clk   (clk),
        .we    (b_adv),
        .waddr (dly_waddr),
        .wdata (fresh[r][p]),
        .re    (issue),
        .raddr (dly_raddr[r]),
        .rdata (dly_rd[r][p])
      );
    end
  end

  always_comb begin
    j_nxt   = issue ? j_r + 1'b1 : j_r;
    b_v_nxt = issue ? 1'b1 : (b_adv ? 1'b0 : b_v_r);
    o_v_nxt = b_adv ? 1'b1 : (out_ch.ready ? 1'b0 : o_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_r   <= '0;
      b_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      j_r   <= j_nxt;
      b_v_r <= b_v_nxt;
      o_v_r <= o_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b_lane_r     <= j_r;
      b_sel0_r     <= m0[chop_pkg::LANE_W];
      b_sel1_r     <= m1[chop_pkg::LANE_W];
      b_fresh_ok_r <= job.fresh_ok;
      b_aged_ok_r  <= job.aged_ok;
      b_odd_r      <= job.odd;
      b_slot_r     <= job.wr_slot;
    end
    if (b_adv) begin
      o_lane_r <= chop_pkg::LANE_FIELD_W'(b_lane_r);
      o_a_r    <= chop_pkg::FIELD_BITS'(b_sel0_r ? aged[0][1] : aged[0][0]);
      o_b_r    <= chop_pkg::FIELD_BITS'(b_sel0_r ? aged[0][0] : aged[0][1]);
      o_c_r    <= chop_pkg::FIELD_BITS'(b_sel1_r ? aged[1][1] : aged[1][0]);
      o_d_r    <= chop_pkg::FIELD_BITS'(b_sel1_r ? aged[1][0] : aged[1][1]);
      o_last_r <= (b_lane_r == chop_pkg::LANE_W'(chop_pkg::LANES - 1));
    end
  end

  assign out_ch.valid        = o_v_r;
  assign out_ch.out_lane     = o_lane_r;
  assign out_ch.out_sample_a = o_a_r;
  assign out_ch.out_sample_b = o_b_r;
  assign out_ch.out_sample_c = o_c_r;
  assign out_ch.out_sample_d = o_d_r;
  assign out_ch.out_last     = o_last_r;

  `CHOP_ASSERT_NOW(a_slot_apart, b_adv && issue, b_slot_r != job.rd_slot, "delay slot read while written")
  `CHOP_ASSERT_NOW(a_call_order, issue && (j_r == '0), !b_v_r || (b_lane_r == chop_pkg::LANE_W'(chop_pkg::LANES - 1)), "call started before previous call ended")
  `CHOP_ASSERT_NEXT(a_read_hold, b_v_r && !b_adv, b_v_r && $stable(b_lane_r) && $stable(aged[0][0]) && $stable(aged[1][1]), "stalled read stage changed")

endmodule

// ----- hdl/channelizer_output_permute.sv -----
// Top level of the channelizer output permutation: front end, job queue, back end, bank store.
// Throughput: one word per cycle on each side unless stalled; a call is eight words each way.
// From a call's last input word, its job passes the job queue, read stage and output register.
// The back end reads the bank store and the delay store once per output word, which sets the rate.
// Reset: synchronous, active low; counters, queue and valid flags clear, stores read as zero.
// The first two calls see an empty bank store and the first four an empty delay store.
module channelizer_output_permute (
  input  logic       clk,
  input  logic       rst_n,
  chop_in_if.sink    in_ch,
  chop_out_if.source out_ch
);

  // The front end accepts one word per cycle, but stalls on a last lane while the queue
  // is full. It writes the four samples of the word into the four banks at row 2*lane+odd
  // of the half that the current call pair owns. The bank store keeps four halves rather
  // than two so that the back end can trail the front end by a few calls without its
  // source rows being overwritten. On the last lane of a call, the front end queues a job
  // that names the half to read, the delay slots to read and write and the rotation step.
  //
  // The back end works one job at a time, one output word per cycle while the receiver is
  // ready. For word i it reads fresh rows i and i+LANES from the bank store and writes
  // them into the delay slot of this call, and reads the aged rows of the call DELAY_CALLS
  // back, rotated by twice the step. The delay store holds one slot more than the delay,
  // so reading and writing never meet in one slot. A registered output stage lets the
  // next word be read while the current one waits to be taken.

  logic                 q_push, q_full, q_valid, q_pop;
  chop_pkg::chop_job_t  q_job, q_head;
  chop_pkg::chop_bwr_t  bwr;
  chop_pkg::chop_brd_t  brd;
  chop_pkg::bank_data_t bdata;
  chop_pkg::sample_t    bank_rd [chop_pkg::BANKS][chop_pkg::PARTS];

  chop_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (q_job),
    .bwr    (bwr)
  );

  chop_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .nonempty (q_valid),
    .head     (q_head),
    .pop      (q_pop)
  );

  // Bank store: each bank is split by the top row bit into two parts, so that rows i
  // and i+LANES can be read in the same cycle.
  for (genvar k = 0; k < chop_pkg::BANKS; k++) begin : g_bank
    for (genvar p = 0; p < chop_pkg::PARTS; p++) begin : g_part
      chop_ram #(
        .WIDTH (chop_pkg::SAMPLE_BITS),
        .DEPTH (chop_pkg::BANK_DEPTH)
      ) u_bank (
        .clk   (clk),
        .we    (bwr.en && (bwr.part == 1'(p))),
        .waddr (bwr.addr),
        .wdata (bwr.data[k]),
        .re    (brd.en),
        .raddr (brd.addr),
        .rdata (bank_rd[k][p])
      );
    end
  end

  always_comb begin
    for (int k = 0; k < chop_pkg::BANKS; k++) begin
      for (int p = 0; p < chop_pkg::PARTS; p++) begin
        bdata[k][p] = bank_rd[k][p];
      end
    end
  end

  chop_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .job     (q_head),
    .q_pop   (q_pop),
    .brd     (brd),
    .bdata   (bdata),
    .out_ch  (out_ch)
  );

endmodule

// ----- sim/channelizer_output_permute_checker.sv -----
// Checker for the channelizer output permutation: predicts every output word and compares it.
`timescale 1ns / 100ps

module channelizer_output_permute_checker (
  input  logic        clk,
  input  logic        rst_n,
  chop_in_if          in_ch,
  chop_out_if         out_ch,
  output int unsigned fail_count,
  output int unsigned words_due,
  output int unsigned words_checked
);
  import chop_pkg::*;

  localparam int ROW_LEN = 2 * LANES;

  typedef struct packed {
    logic [LANE_FIELD_W-1:0] lane;
    sample_t                 a;
    sample_t                 b;
    sample_t                 c;
    sample_t                 d;
    logic                    last;
  } lane_word_t;

  // Private copy of the block's state.
  sample_t             bank_mem [2][BANKS][ROW_LEN];
  sample_t             delay_mem [DELAY_CALLS][2][ROW_LEN];
  logic [LANE_W-1:0]   lane_idx;
  logic                odd_q;
  logic                half_q;
  int                  delay_slot;
  logic [STEP_W-1:0]   rot_step;

  lane_word_t          lane_words_due [$];
  int unsigned         err_cnt;
  int unsigned         chk_cnt;

  task automatic clear_state();
    foreach (bank_mem[h, k, m]) bank_mem[h][k][m] = '0;
    foreach (delay_mem[s, r, m]) delay_mem[s][r][m] = '0;
    lane_idx   = '0;
    odd_q      = 1'b0;
    half_q     = 1'b0;
    delay_slot = 0;
    rot_step   = '0;
    lane_words_due.delete();
  endtask

  // Stores one input word; on the last lane of a call it queues the call's output words.
  task automatic permute_word(input sample_t a, input sample_t b, input sample_t c,
                              input sample_t d);
    sample_t           smp [BANKS];
    sample_t           fresh [2][ROW_LEN];
    sample_t           aged [2][ROW_LEN];
    int                row;
    int                shift0;
    int                shift1;
    logic [STEP_W-1:0] step1;
    lane_word_t        w;
    smp[0] = a;
    smp[1] = b;
    smp[2] = c;
    smp[3] = d;
    row = (2 * lane_idx + odd_q) % ROW_LEN;
    for (int k = 0; k < BANKS; k++) bank_mem[half_q][k][row] = smp[k];
    if (lane_idx != LANE_W'(LANES - 1)) begin
      lane_idx = lane_idx + 1'b1;
      return;
    end
    lane_idx = '0;

    for (int m = 0; m < ROW_LEN; m++) begin
      fresh[0][m] = bank_mem[half_q ^ 1'b1][odd_q ? 2 : 0][m];
      fresh[1][m] = bank_mem[half_q ^ 1'b1][odd_q ? 3 : 1][m];
    end
    for (int r = 0; r < 2; r++) begin
      for (int m = 0; m < ROW_LEN; m++) begin
        aged[r][m]                  = delay_mem[delay_slot][r][m];
        delay_mem[delay_slot][r][m] = fresh[r][m];
      end
    end
    delay_slot = (delay_slot + 1 >= DELAY_CALLS) ? 0 : delay_slot + 1;

    step1    = rot_step + 1'b1;
    shift0   = (2 * rot_step) % ROW_LEN;
    shift1   = (2 * step1) % ROW_LEN;
    rot_step = rot_step + 2'd2;

    for (int i = 0; i < LANES; i++) begin
      w.lane = LANE_FIELD_W'(i);
      w.a    = aged[0][(i + shift0) % ROW_LEN];
      w.b    = aged[0][(i + LANES + shift0) % ROW_LEN];
      w.c    = aged[1][(i + shift1) % ROW_LEN];
      w.d    = aged[1][(i + LANES + shift1) % ROW_LEN];
      w.last = (i == LANES - 1);
      lane_words_due.push_back(w);
    end

    if (odd_q) half_q = ~half_q;
    odd_q = ~odd_q;
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_cnt++;
    end
  endfunction

  task automatic check_word();
    lane_word_t want;
    if (lane_words_due.size() == 0) begin
      $error("output word on lane %0d with no prediction pending", out_ch.out_lane);
      err_cnt++;
      return;
    end
    want = lane_words_due.pop_front();
    chk_cnt++;
    check_field("out_lane", 32'(want.lane), 32'(out_ch.out_lane));
    check_field("out_sample_a", want.a, out_ch.out_sample_a);
    check_field("out_sample_b", want.b, out_ch.out_sample_b);
    check_field("out_sample_c", want.c, out_ch.out_sample_c);
    check_field("out_sample_d", want.d, out_ch.out_sample_d);
    check_field("out_last", 32'(want.last), 32'(out_ch.out_last));
  endtask

  initial begin
    err_cnt = 0;
    chk_cnt = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        permute_word(in_ch.in_sample_a, in_ch.in_sample_b, in_ch.in_sample_c,
                     in_ch.in_sample_d);
      end
      if (out_ch.valid && out_ch.ready) begin
        check_word();
      end
    end
    fail_count    <= err_cnt;
    words_due     <= lane_words_due.size();
    words_checked <= chk_cnt;
  end

endmodule

// ----- sim/channelizer_output_permute_tb.sv -----
// Testbench top of the channelizer output permutation: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module channelizer_output_permute_tb;
  import chop_pkg::*;

  // Three directed calls, then random calls: 54 calls of eight words, 432 input words.
  localparam int DIRECTED_CALLS = 3;
  localparam int RANDOM_CALLS   = 51;
  // The call at which the receiver is asked for its long hold-off, and the call before
  // which the sender waits for every predicted word to come out.
  localparam int HOLD_CALL      = 8;
  localparam int DRAIN_CALL     = 30;
  localparam int LONG_HOLD      = 400;
  // The worst legal quiet stretch is the long hold-off plus one receiver stall; the
  // watchdog allows several times that before it calls the run hung.
  localparam int IDLE_LIMIT     = 3000;
  // This tail leaves room for any stray word after the last prediction has been met.
  localparam int TAIL_CYCLES    = 16;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        hold_req;
  int unsigned fail_count;
  int unsigned words_due;
  int unsigned words_checked;
  int unsigned words_sent;

  chop_in_if  in_ch ();
  chop_out_if out_ch ();

  channelizer_output_permute u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // The checker watches both channels, keeps its own model of the permutation and
  // reports its failure count and the number of output words still owed.
  channelizer_output_permute_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .words_due     (words_due),
    .words_checked (words_checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Gap length used by both sides: mostly none, often a few cycles, now and then long.
  function automatic int unsigned idle_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random sample that leans toward the corners: zero, all ones, one bit set or clear.
  function automatic sample_t random_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return sample_t'(1) << $urandom_range(0, SAMPLE_BITS - 1);
      3: return ~(sample_t'(1) << $urandom_range(0, SAMPLE_BITS - 1));
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Offers one word and returns at the edge at which it is taken. Valid stays high, so a
  // following call with no gap presents the next word back to back.
  task automatic push_word(input sample_t a, input sample_t b, input sample_t c,
                           input sample_t d);
    in_ch.valid       <= 1'b1;
    in_ch.in_sample_a <= a;
    in_ch.in_sample_b <= b;
    in_ch.in_sample_c <= c;
    in_ch.in_sample_d <= d;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic hold_off_sender(input int unsigned cycles);
    if (cycles != 0) begin
      in_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Drops valid and waits until the checker owes no more output words. The count it
  // reports is registered, so it is looked at only from the next edge on.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
  endtask

  // Stimulus. Directed calls first: every sample at all ones, then checkerboards that
  // flip with the lane, then tagged samples whose bank and lane can be read back from
  // the output, which makes a wrong rotation or a wrong bank easy to spot. These calls
  // come out of the delay only after the warm-up calls, which return zeros. The random
  // calls after that run past several wraps of the rotation step and the delay pointer.
  initial begin : stimulus
    bit burst;
    rst_n             <= 1'b0;
    hold_req          <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.in_sample_a <= '0;
    in_ch.in_sample_b <= '0;
    in_ch.in_sample_c <= '0;
    in_ch.in_sample_d <= '0;
    words_sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int lane = 0; lane < LANES; lane++) begin
      push_word('1, '1, '1, '1);
    end
    for (int lane = 0; lane < LANES; lane++) begin
      if (lane % 2 == 0) begin
        push_word(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
      end else begin
        push_word(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
      end
    end
    for (int lane = 0; lane < LANES; lane++) begin
      push_word({8'hA0, 16'h0F0F, 8'(lane)}, {8'hB1, 16'h0F0F, 8'(lane)},
                {8'hC2, 16'h0F0F, 8'(lane)}, {8'hD3, 16'h0F0F, 8'(lane)});
    end

    // Random calls. About one call in four goes out back to back with no gaps.
    for (int call = 0; call < RANDOM_CALLS; call++) begin
      burst = ($urandom_range(0, 3) == 0);
      // Ask the receiver to hold off while words keep coming, so the block backs up.
      if (call == HOLD_CALL) hold_req <= 1'b1;
      // Once in the run the sender stops until the block has handed out everything.
      if (call == DRAIN_CALL) wait_drained();
      for (int lane = 0; lane < LANES; lane++) begin
        if (!burst) hold_off_sender(idle_length());
        push_word(random_sample(), random_sample(), random_sample(), random_sample());
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run: %0d input words in %0d calls, %0d output words checked.",
             words_sent, DIRECTED_CALLS + RANDOM_CALLS, words_checked);
    $display("Covered delay warm-up, all rotation steps, a %0d-cycle output hold-off "
             , LONG_HOLD, "and a full drain mid-run.");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Receiver. Stalls of random length alternate with runs of ready, some of them long.
  // When the stimulus asks for it, ready goes low once for a long stretch counted here.
  initial begin : result_sink
    int unsigned stall;
    int unsigned run;
    bit          held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held  = 1'b1;
        stall = LONG_HOLD;
      end else begin
        stall = idle_length();
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      run = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
      out_ch.ready <= 1'b1;
      repeat (run) @(posedge clk);
    end
  end

  // Watchdog: counts cycles in which no word moves on either channel.
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Timeout: %0d cycles with no word moving, %0d output words still owed.",
             IDLE_LIMIT, words_due);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/chop_pkg.sv
hdl/chop_if.sv
hdl/chop_ram.sv
hdl/chop_front.sv
hdl/chop_queue.sv
hdl/chop_back.sv
hdl/channelizer_output_permute.sv
sim/channelizer_output_permute_checker.sv
sim/channelizer_output_permute_tb.sv
